// ===== src/chained_hash_table_int_pair_macros.svh =====
// Assertion helpers for the hash table RTL. Both sample on clk and stay quiet in reset.
`ifndef CHAINED_HASH_TABLE_INT_PAIR_MACROS_SVH
`define CHAINED_HASH_TABLE_INT_PAIR_MACROS_SVH

// Invariant that must hold at every edge out of reset.
`define CHT_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent this cycle implies consequent next cycle.
`define CHT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/cht_pkg.sv =====
`default_nettype none
package cht_pkg;

  localparam int BUCKETS_DEF = 256;
  localparam int NODES_DEF   = 1024;
  localparam int HASH_SHIFT  = 16;
  localparam int WORD_W      = 32;
  localparam int ENTRY_W     = 11;
  localparam int OCC_W       = 9;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_FIND = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NF    = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [WORD_W-1:0] key_first;
    logic [WORD_W-1:0] key_second;
    logic [WORD_W-1:0] data_value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [WORD_W-1:0]  data_out;
    logic [1:0]         status;
    logic [ENTRY_W-1:0] entry_count;
    logic [OCC_W-1:0]   occupied_count;
  } rsp_t;

endpackage
`default_nettype wire

// ===== src/chained_hash_table_int_pair.sv =====
// Channel | Ports                          | Moves
// in      | in_valid in_ready in_data      | one request: cmd, key pair, data
// out     | out_valid out_ready out_data   | one result per request
//
// Each request passes S_HASH, S_HEAD, the chain walk (S_WALK) where needed and
// S_DONE; a bucket remainder unit is used when BUCKETS is not a power of two.
// The chain walk reads one node per cycle from the node memory.
// Reset: rst_n low for one edge; no clearing pass, fresh nodes come from a counter.
// A result held by out_ready low stalls the next request only at its end.
`default_nettype none
module chained_hash_table_int_pair import cht_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int NODES   = NODES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_ready,
  input  wire req_t in_data,
  output      logic out_valid,
  input  wire logic out_ready,
  output      rsp_t out_data
);

`include "chained_hash_table_int_pair_macros.svh"

  localparam int IW = $clog2(NODES);
  localparam int BW = $clog2(BUCKETS);
  localparam int CW = $clog2(NODES + 1);
  localparam int OW = $clog2(BUCKETS + 1);
  // node word: {key_first, key_second, data, has_next, next}
  localparam int NW = 3*WORD_W + 1 + IW;

  typedef enum logic [2:0] {S_IDLE, S_HASH, S_HEAD, S_WALK, S_DONE} state_t;

  state_t          state_r, state_nxt;
  req_t            req_r, req_nxt;
  logic [BW-1:0]   bkt_r, bkt_nxt;
  logic [IW-1:0]   cur_r, cur_nxt;
  logic [IW-1:0]   prev_r, prev_nxt;
  logic [NW-1:0]   prev_word_r, prev_word_nxt;
  logic            has_prev_r, has_prev_nxt;
  logic [CW-1:0]   steps_r, steps_nxt;
  logic [IW-1:0]   newn_r, newn_nxt;
  logic [CW-1:0]   stack_cnt_r, stack_cnt_nxt;  // freed nodes on the stack
  logic [CW-1:0]   fresh_r, fresh_nxt;          // nodes never handed out start here
  logic [CW-1:0]   entries_r, entries_nxt;
  logic [OW-1:0]   occ_r, occ_nxt;
  logic            found_r, found_nxt;
  logic [WORD_W-1:0] dout_r, dout_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            out_valid_r, out_valid_nxt;
  rsp_t            out_data_r, out_data_nxt;
  logic            bvalid_r [BUCKETS];
  logic            bv_set, bv_clr;

  // hash unit
  logic              hash_start, hash_done;
  logic [BW-1:0]     hash_bucket;
  logic [WORD_W-1:0] hash_val;

  // memory ports
  logic          head_we;
  logic [IW-1:0] head_wdata, head_rdata;
  logic [BW-1:0] head_raddr;
  logic          node_we;
  logic [IW-1:0] node_waddr, node_raddr;
  logic [NW-1:0] node_wdata, node_rdata;
  logic          stk_we;
  logic [IW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  // fields of the node word just read
  logic [WORD_W-1:0] nd_kf, nd_ks, nd_data;
  logic              nd_hn;
  logic [IW-1:0]     nd_next;
  logic              nd_match;
  logic [CW-1:0]     steps_inc;
  logic              bv;
  logic              pool_empty;
  logic [IW-1:0]     pick;

  assign hash_val = in_data.key_first + {in_data.key_second[WORD_W-HASH_SHIFT-1:0],
                                         {HASH_SHIFT{1'b0}}};

  cht_hash_mod #(.BUCKETS(BUCKETS)) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .hash   (hash_val),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  cht_ram #(.WIDTH(IW), .DEPTH(BUCKETS)) u_head (
    .clk(clk), .we(head_we), .waddr(bkt_r), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  cht_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  cht_ram #(.WIDTH(IW), .DEPTH(NODES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign {nd_kf, nd_ks, nd_data, nd_hn, nd_next} = node_rdata;
  assign nd_match   = (nd_kf == req_r.key_first) && (nd_ks == req_r.key_second);
  assign steps_inc  = steps_r + CW'(1);
  assign bv         = bvalid_r[bkt_r];
  assign pool_empty = (stack_cnt_r == '0) && (fresh_r == CW'(NODES));
  // reuse a freed node first, else the next fresh one
  assign pick       = (stack_cnt_r != '0) ? stk_rdata : fresh_r[IW-1:0];

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    bkt_nxt       = bkt_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    prev_word_nxt = prev_word_r;
    has_prev_nxt  = has_prev_r;
    steps_nxt     = steps_r;
    newn_nxt      = newn_r;
    stack_cnt_nxt = stack_cnt_r;
    fresh_nxt     = fresh_r;
    entries_nxt   = entries_r;
    occ_nxt       = occ_r;
    found_nxt     = found_r;
    dout_nxt      = dout_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    bv_set        = 1'b0;
    bv_clr        = 1'b0;
    hash_start    = 1'b0;
    head_we       = 1'b0;
    head_wdata    = '0;
    head_raddr    = hash_bucket;
    node_we       = 1'b0;
    node_waddr    = cur_r;
    node_wdata    = node_rdata;
    node_raddr    = cur_r;
    stk_we        = 1'b0;
    stk_waddr     = stack_cnt_r[IW-1:0];
    stk_wdata     = cur_r;
    stk_raddr     = IW'(stack_cnt_r - CW'(1));

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          hash_start = 1'b1;
          found_nxt  = 1'b0;
          dout_nxt   = '0;
          status_nxt = ST_OK;
          state_nxt  = S_HASH;
        end
      end

      S_HASH: begin
        // head and stack-top reads go out with the bucket
        if (hash_done) begin
          bkt_nxt   = hash_bucket;
          state_nxt = S_HEAD;
        end
      end

      S_HEAD: begin
        cur_nxt      = head_rdata;
        node_raddr   = head_rdata;
        steps_nxt    = '0;
        has_prev_nxt = 1'b0;
        case (req_r.cmd)
          CMD_ADD: begin
            if (pool_empty) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              newn_nxt   = pick;
              if (stack_cnt_r != '0) begin
                stack_cnt_nxt = stack_cnt_r - CW'(1);
              end else begin
                fresh_nxt = fresh_r + CW'(1);
              end
              // counted with the node hand-out so the node tally stays balanced
              entries_nxt = entries_r + CW'(1);
              node_we    = 1'b1;
              node_waddr = pick;
              node_wdata = {req_r.key_first, req_r.key_second, req_r.data_value,
                            1'b0, {IW{1'b0}}};
              if (!bv) begin
                head_we     = 1'b1;
                head_wdata  = pick;
                bv_set      = 1'b1;
                occ_nxt     = occ_r + OW'(1);
                state_nxt   = S_DONE;
              end else begin
                state_nxt = S_WALK;
              end
            end
          end
          CMD_FIND, CMD_DEL: begin
            if (!bv) begin
              status_nxt = ST_NF;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_WALK;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_WALK: begin
        if (req_r.cmd == CMD_ADD) begin
          if (nd_hn && (steps_r < CW'(NODES))) begin
            cur_nxt    = nd_next;
            node_raddr = nd_next;
            steps_nxt  = steps_inc;
          end else begin
            // link the new node behind the tail
            node_we     = 1'b1;
            node_waddr  = cur_r;
            node_wdata  = {nd_kf, nd_ks, nd_data, 1'b1, newn_r};
            state_nxt   = S_DONE;
          end
        end else if (nd_match) begin
          found_nxt  = 1'b1;
          dout_nxt   = nd_data;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          if (req_r.cmd == CMD_DEL) begin
            if (!has_prev_r) begin
              if (nd_hn) begin
                head_we    = 1'b1;
                head_wdata = nd_next;
              end else begin
                bv_clr  = 1'b1;
                occ_nxt = occ_r - OW'(1);
              end
            end else begin
              node_we    = 1'b1;
              node_waddr = prev_r;
              node_wdata = {prev_word_r[NW-1:IW+1], nd_hn, nd_next};
            end
            if (stack_cnt_r < fresh_r) begin
              stk_we        = 1'b1;
              stack_cnt_nxt = stack_cnt_r + CW'(1);
            end
            entries_nxt = entries_r - CW'(1);
          end
        end else begin
          steps_nxt = steps_inc;
          if (!nd_hn || (steps_inc >= CW'(NODES))) begin
            status_nxt = ST_NF;
            state_nxt  = S_DONE;
          end else begin
            prev_word_nxt = node_rdata;
            prev_nxt      = cur_r;
            has_prev_nxt  = 1'b1;
            cur_nxt       = nd_next;
            node_raddr    = nd_next;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{found:          found_r,
                            data_out:       dout_r,
                            status:         status_r,
                            entry_count:    ENTRY_W'(entries_r),
                            occupied_count: OCC_W'(occ_r)};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stack_cnt_r <= '0;
      fresh_r     <= '0;
      entries_r   <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < BUCKETS; i++) begin
        bvalid_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      stack_cnt_r <= stack_cnt_nxt;
      fresh_r     <= fresh_nxt;
      entries_r   <= entries_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      if (bv_set) begin
        bvalid_r[bkt_r] <= 1'b1;
      end else if (bv_clr) begin
        bvalid_r[bkt_r] <= 1'b0;
      end
    end
    req_r       <= req_nxt;
    bkt_r       <= bkt_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    prev_word_r <= prev_word_nxt;
    has_prev_r  <= has_prev_nxt;
    steps_r     <= steps_nxt;
    newn_r      <= newn_nxt;
    found_r     <= found_nxt;
    dout_r      <= dout_nxt;
    status_r    <= status_nxt;
    out_data_r  <= out_data_nxt;
  end

  // every node is either stored, on the free stack, or never handed out
  `CHT_CHECK(a_node_conservation, (CW+1)'(entries_r) + (CW+1)'(stack_cnt_r) == (CW+1)'(fresh_r), "node count mismatch")
  `CHT_CHECK(a_occ_le_entries, (CW+OW)'(occ_r) <= (CW+OW)'(entries_r), "more buckets than entries")
  `CHT_CHECK(a_fresh_bound, fresh_r <= CW'(NODES), "fresh counter overran pool")
  `CHT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "took two requests at once")

endmodule
`default_nettype wire

// ===== src/cht_ram.sv =====
`default_nettype none
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/cht_hash_mod.sv =====
`default_nettype none
module cht_hash_mod import cht_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [WORD_W-1:0]          hash,
  output      logic                       done,
  output      logic [$clog2(BUCKETS)-1:0] bucket
);

  localparam int BW = $clog2(BUCKETS);

  generate
    if ((1 << BW) == BUCKETS) begin : g_pow2
      // power of two: remainder is the low bits
      logic          done_r;
      logic [BW-1:0] bkt_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          bkt_r <= hash[BW-1:0];
        end
      end
      assign done   = done_r;
      assign bucket = bkt_r;
    end else begin : g_div
      // restoring remainder, 4 dividend bits per cycle, over the whole hash word
      logic              busy_r;
      logic              done_r;
      logic [2:0]        cnt_r;
      logic [WORD_W-1:0] sh_r;
      logic [BW-1:0]     rem_r;
      logic [BW-1:0]     rem_nxt;
      logic [BW:0]       t;

      always_comb begin
        rem_nxt = rem_r;
        t       = '0;
        for (int i = 0; i < 4; i++) begin
          t = {rem_nxt, sh_r[WORD_W-1-i]};
          if (t >= (BW+1)'(BUCKETS)) begin
            t = t - (BW+1)'(BUCKETS);
          end
          rem_nxt = t[BW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            busy_r <= 1'b1;
            cnt_r  <= '0;
          end else if (busy_r) begin
            cnt_r <= cnt_r + 3'd1;
            if (cnt_r == 3'd7) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
        if (start) begin
          sh_r  <= hash;
          rem_r <= '0;
        end else if (busy_r) begin
          sh_r  <= sh_r << 4;
          rem_r <= rem_nxt;
        end
      end
      assign done   = done_r;
      assign bucket = rem_r;
    end
  endgenerate

endmodule
`default_nettype wire

// ===== sim/tb_chained_hash_table_int_pair.sv =====
`default_nettype none
module tb_chained_hash_table_int_pair;
  import cht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         NB        = BUCKETS_DEF;
  localparam int         NN        = NODES_DEF;
  localparam logic [1:0] CMD_NOP   = 2'd3;   // unused opcode, table untouched
  localparam int         CYC_LIMIT = 2000000;
  localparam int         N_RANDOM  = 430;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  always #1 clk = ~clk;

  chained_hash_table_int_pair u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow table: mirrors the chained hash table, one node per pool slot.
  // ---------------------------------------------------------------------------
  bit          sh_bvalid [NB];
  logic [9:0]  sh_head   [NB];
  logic [31:0] sh_k0     [NN];
  logic [31:0] sh_k1     [NN];
  logic [31:0] sh_data   [NN];
  logic [9:0]  sh_next   [NN];
  bit          sh_hasnx  [NN];
  logic [9:0]  sh_free   [NN];
  int          sh_nfree;
  int          sh_entries;
  int          sh_occ;

  rsp_t        result_q[$];   // expected results, oldest first
  int          errors = 0;
  bit          calm = 1'b0;   // no idling on either side while set
  logic [31:0] key_pool0[$];  // keys added so far, used to hit stored entries
  logic [31:0] key_pool1[$];

  function automatic logic [7:0] bucket_of(logic [31:0] k0, logic [31:0] k1);
    logic [31:0] h;
    h = k0 + (k1 << HASH_SHIFT);
    return h[7:0];
  endfunction

  // Apply one request to the shadow table and return the result it yields.
  function automatic rsp_t table_update(req_t r);
    rsp_t        o;
    logic [7:0]  b;
    logic [9:0]  n, cur, prv;
    bit          has_prv;
    int          steps;
    o = '0;
    b = bucket_of(r.key_first, r.key_second);
    if (r.cmd == CMD_ADD) begin
      if (sh_nfree == 0) begin
        o.status = ST_FULL;
      end else begin
        sh_nfree--;
        n = sh_free[sh_nfree];
        sh_k0[n] = r.key_first;
        sh_k1[n] = r.key_second;
        sh_data[n] = r.data_value;
        sh_hasnx[n] = 1'b0;
        sh_next[n] = '0;
        if (!sh_bvalid[b]) begin
          sh_bvalid[b] = 1'b1;
          sh_head[b] = n;
          sh_occ++;
        end else begin
          cur = sh_head[b];
          steps = 0;
          while (sh_hasnx[cur] && steps < NN) begin
            cur = sh_next[cur];
            steps++;
          end
          sh_next[cur] = n;
          sh_hasnx[cur] = 1'b1;
        end
        sh_entries++;
      end
    end else if (r.cmd == CMD_FIND || r.cmd == CMD_DEL) begin
      o.status = ST_NF;
      if (sh_bvalid[b]) begin
        cur = sh_head[b];
        prv = '0;
        has_prv = 1'b0;
        steps = 0;
        forever begin
          if (sh_k0[cur] == r.key_first && sh_k1[cur] == r.key_second) begin
            o.found = 1'b1;
            o.status = ST_OK;
            o.data_out = sh_data[cur];
            if (r.cmd == CMD_DEL) begin
              if (!has_prv) begin
                if (sh_hasnx[cur]) sh_head[b] = sh_next[cur];
                else begin
                  sh_bvalid[b] = 1'b0;
                  sh_occ--;
                end
              end else begin
                sh_next[prv] = sh_next[cur];
                sh_hasnx[prv] = sh_hasnx[cur];
              end
              if (sh_nfree < NN) begin
                sh_free[sh_nfree] = cur;
                sh_nfree++;
              end
              sh_entries--;
            end
            break;
          end
          steps++;
          if (!sh_hasnx[cur] || steps >= NN) break;
          prv = cur;
          has_prv = 1'b1;
          cur = sh_next[cur];
        end
      end
    end
    o.entry_count = sh_entries[ENTRY_W-1:0];
    o.occupied_count = sh_occ[OCC_W-1:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Each request waits a random gap, then holds valid until the
  // block takes it; the shadow table is updated at the accepting edge.
  // ---------------------------------------------------------------------------
  task automatic send_request(req_t r, bit typed, rsp_t typed_rsp);
    int   gap;
    rsp_t p;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    p = table_update(r);
    result_q.push_back(typed ? typed_rsp : p);
    if (r.cmd == CMD_ADD) begin
      key_pool0.push_back(r.key_first);
      key_pool1.push_back(r.key_second);
    end
  endtask

  function automatic req_t mk(logic [1:0] c, logic [31:0] k0, logic [31:0] k1,
                              logic [31:0] d);
    req_t r;
    r.cmd = c;
    r.key_first = k0;
    r.key_second = k1;
    r.data_value = d;
    return r;
  endfunction

  function automatic rsp_t mkr(bit f, logic [31:0] d, logic [1:0] s, int e, int o);
    rsp_t x;
    x.found = f;
    x.data_out = d;
    x.status = s;
    x.entry_count = e[ENTRY_W-1:0];
    x.occupied_count = o[OCC_W-1:0];
    return x;
  endfunction

  // Random request: mostly keys already stored or sharing their bucket, so
  // chains grow and finds and deletes hit; the rest is fully random bits.
  function automatic req_t random_request(logic [1:0] c);
    logic [31:0] k0, k1;
    int          idx;
    k0 = $urandom;
    k1 = $urandom;
    if (key_pool0.size() > 0 && $urandom_range(0, 99) < 70) begin
      idx = $urandom_range(0, key_pool0.size() - 1);
      k0 = key_pool0[idx];
      k1 = key_pool1[idx];
      // same bucket, different key
      if (c == CMD_ADD && $urandom_range(0, 1)) k0 = k0 + ($urandom_range(1, 255) << 8);
    end
    return mk(c, k0, k1, $urandom);
  endfunction

  function automatic logic [1:0] random_cmd();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return CMD_ADD;
    if (p < 75) return CMD_FIND;
    if (p < 95) return CMD_DEL;
    return CMD_NOP;
  endfunction

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t e;
  } stim_row_t;

  stim_row_t dir_rows[$];
  rsp_t      none_rsp;

  initial begin
    none_rsp = '0;
    // empty table: misses, then extreme keys and data
    dir_rows.push_back('{mk(CMD_FIND, 32'h0, 32'h0, 32'h0), 1,
                         mkr(0, 0, ST_NF, 0, 0)});
    dir_rows.push_back('{mk(CMD_DEL, '1, '1, '1), 1, mkr(0, 0, ST_NF, 0, 0)});
    dir_rows.push_back('{mk(CMD_ADD, 32'h0, 32'h0, '1), 1, mkr(0, 0, ST_OK, 1, 1)});
    dir_rows.push_back('{mk(CMD_ADD, '1, '1, 32'h0), 1, mkr(0, 0, ST_OK, 2, 2)});
    dir_rows.push_back('{mk(CMD_FIND, 32'h0, 32'h0, 32'h0), 1,
                         mkr(1, '1, ST_OK, 2, 2)});
    // build a chain of four in bucket zero
    dir_rows.push_back('{mk(CMD_ADD, 32'h100, 32'h0, 32'h5a5a5a5a), 1,
                         mkr(0, 0, ST_OK, 3, 2)});
    dir_rows.push_back('{mk(CMD_ADD, 32'h200, 32'h0, 32'h1), 1, mkr(0, 0, ST_OK, 4, 2)});
    dir_rows.push_back('{mk(CMD_ADD, 32'h0, 32'h1, 32'h2), 1, mkr(0, 0, ST_OK, 5, 2)});
    dir_rows.push_back('{mk(CMD_FIND, 32'h200, 32'h0, 32'h0), 0, none_rsp});
    dir_rows.push_back('{mk(CMD_DEL, 32'h100, 32'h0, 32'h0), 0, none_rsp});  // middle
    dir_rows.push_back('{mk(CMD_FIND, 32'h100, 32'h0, 32'h0), 0, none_rsp});
    dir_rows.push_back('{mk(CMD_DEL, 32'h0, 32'h0, 32'h0), 0, none_rsp});    // head
    dir_rows.push_back('{mk(CMD_DEL, 32'h0, 32'h1, 32'h0), 0, none_rsp});    // tail
    dir_rows.push_back('{mk(CMD_FIND, 32'h200, 32'h0, 32'h0), 0, none_rsp});
    dir_rows.push_back('{mk(CMD_NOP, '1, '1, '1), 0, none_rsp});
    // duplicate key: find returns the first one added
    dir_rows.push_back('{mk(CMD_ADD, 32'h200, 32'h0, 32'h7), 0, none_rsp});
    dir_rows.push_back('{mk(CMD_FIND, 32'h200, 32'h0, 32'h0), 0, none_rsp});
    dir_rows.push_back('{mk(CMD_DEL, 32'h200, 32'h0, 32'h0), 0, none_rsp});
    dir_rows.push_back('{mk(CMD_DEL, 32'h200, 32'h0, 32'h0), 0, none_rsp});
    dir_rows.push_back('{mk(CMD_DEL, 32'h200, 32'h0, 32'h0), 0, none_rsp});  // miss
    dir_rows.push_back('{mk(CMD_DEL, '1, '1, 32'h0), 0, none_rsp});          // empties
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < NN; i++) sh_free[i] = i[9:0];
    for (int i = 0; i < NB; i++) sh_bvalid[i] = 1'b0;
    sh_nfree = NN;
    sh_entries = 0;
    sh_occ = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_request(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);

    // mixed traffic, with a back-to-back stretch in the middle
    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 200 && i < 280);
      send_request(random_request(random_cmd()), 0, none_rsp);
    end

    // drain a batch of entries, then mix again
    for (int i = 0; i < 60; i++) send_request(random_request(CMD_DEL), 0, none_rsp);
    for (int i = 0; i < 40; i++) send_request(random_request(random_cmd()), 0, none_rsp);

    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stall drawn per result.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        e = result_q.pop_front();
        if (out_data.found !== e.found) begin
          $display("%0t: found exp %0d got %0d", $time, e.found, out_data.found);
          errors++;
        end
        if (out_data.data_out !== e.data_out) begin
          $display("%0t: data_out exp %h got %h", $time, e.data_out, out_data.data_out);
          errors++;
        end
        if (out_data.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
          errors++;
        end
        if (out_data.entry_count !== e.entry_count) begin
          $display("%0t: entry_count exp %0d got %0d", $time, e.entry_count,
                   out_data.entry_count);
          errors++;
        end
        if (out_data.occupied_count !== e.occupied_count) begin
          $display("%0t: occupied_count exp %0d got %0d", $time, e.occupied_count,
                   out_data.occupied_count);
          errors++;
        end
      end
    end
  end

  // Watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYC_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/cht_pkg.sv
src/cht_ram.sv
src/cht_hash_mod.sv
src/chained_hash_table_int_pair.sv
sim/tb_chained_hash_table_int_pair.sv
